/* rtl/smm_pkg.sv */
// smm_pkg: item types, action codes and fixed widths for square_matrix_multiply
// no dependencies; imported by every module of the block
package smm_pkg;

	// fixed field widths
	localparam int unsigned IDX_FIELD_BITS = 6;
	localparam int unsigned VALUE_BITS     = 16;
	localparam int unsigned SIZE_BITS      = 7;
	localparam int unsigned SUM_BITS       = 40;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

	// action codes
	localparam logic [1:0] ACT_WR_FIRST  = 2'd0;
	localparam logic [1:0] ACT_WR_SECOND = 2'd1;
	localparam logic [1:0] ACT_REQUEST   = 2'd2;
	localparam logic [1:0] ACT_NONE      = 2'd3;

	// input item
	typedef struct packed {
		logic [1:0]                     action;
		logic [IDX_FIELD_BITS-1:0]      row;
		logic [IDX_FIELD_BITS-1:0]      col;
		logic signed [VALUE_BITS-1:0]   value;
	} req_item_t;

	// result item
	typedef struct packed {
		logic signed [SUM_BITS-1:0] product_sum;
		logic                       index_error;
	} rsp_item_t;

	// control into the multiply-accumulate unit
	typedef struct packed {
		logic clr;
		logic vld;
		logic last;
	} mac_ctl_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_RESULT = 4'b1000
	} seq_state_t;

endpackage

/* rtl/smm_ram.sv */
// smm_ram: one matrix store, one write port and one registered read port
// depends on smm_pkg for house types only
module smm_ram import smm_pkg::*; #(
	parameter int unsigned WIDTH     = 16,
	parameter int unsigned ADDR_BITS = 12
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_BITS];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/smm_mac.sv */
// smm_mac: shared multiply-accumulate unit, product register then accumulator
// depends on smm_pkg for mac_ctl_t and SUM_BITS
module smm_mac import smm_pkg::*; #(
	parameter int unsigned ELEMENT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctl_t                       ctl,
	input  logic signed [ELEMENT_BITS-1:0] a,
	input  logic signed [ELEMENT_BITS-1:0] b,
	output logic signed [SUM_BITS-1:0]     sum,
	output logic                           done
);

	localparam int unsigned PROD_BITS = 2 * ELEMENT_BITS;

	logic signed [PROD_BITS-1:0] prod_s2;
	logic                        vld_s2;
	logic                        last_s2;
	logic signed [SUM_BITS-1:0]  acc_q;
	logic                        done_q;

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	// control follows the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s2  <= ctl.vld;
			last_s2 <= ctl.last;
			done_q  <= vld_s2 && last_s2;
		end
	end

	// accumulate, wrapping at the sum width
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + SUM_BITS'(prod_s2);
		end
	end

	assign sum  = acc_q;
	assign done = done_q;

endmodule

/* rtl/square_matrix_multiply.sv */
// square_matrix_multiply: top level with sequencer, matrix stores and result register
// depends on smm_pkg, smm_ram and smm_mac
//
// Two square matrices of signed Q8.8 elements are held in on-chip memories of
// MAX_SIZE x MAX_SIZE entries each, with no reset and no clearing pass; an entry
// must be written before any request reads it. A write item returns a result
// with product_sum zero and index_error set when row or col is not below the
// size in use (the write is then dropped). A request whose indices are in range
// walks one row of the first matrix and one column of the second through a
// single shared multiply-accumulate unit, one term per cycle, and occupies the
// block through one issue per term, the memory read, product and accumulate
// registers, and the result hand-off. A request out of range answers at once
// with zero and index_error set. Action three is taken and gives no result. A
// size above MAX_SIZE acts as MAX_SIZE, and size zero flags every item. The sum
// is exact in Q24.16 and wraps at 40 bits. The block holds off new items while
// a request is in progress or while a result is waiting and stalled; the size
// register may be written only while idle.
module square_matrix_multiply import smm_pkg::*; #(
	parameter int unsigned MAX_SIZE     = 64,
	parameter int unsigned ELEMENT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_item_t            req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_item_t            rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SIZE_BITS-1:0] cfg_data
);

	localparam int unsigned IDX_BITS  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int unsigned ADDR_BITS = 2 * IDX_BITS;
	localparam int unsigned CNT_BITS  = $clog2(MAX_SIZE + 1);
	localparam int unsigned CMP_BITS  = (CNT_BITS > SIZE_BITS) ? CNT_BITS : SIZE_BITS;
	localparam logic [CMP_BITS-1:0] MAX_CMP = CMP_BITS'(MAX_SIZE);

	seq_state_t state_q;
	seq_state_t state_d;

	logic [SIZE_BITS-1:0]   size_q;
	logic [CMP_BITS-1:0]    size_ext;
	logic [CMP_BITS-1:0]    n_act;
	logic [CNT_BITS-1:0]    n_q;
	logic [CNT_BITS-1:0]    k_q;
	logic [IDX_BITS-1:0]    row_q;
	logic [IDX_BITS-1:0]    col_q;
	logic [IDX_BITS-1:0]    k_idx;
	logic [IDX_BITS-1:0]    in_row;
	logic [IDX_BITS-1:0]    in_col;

	logic                   accept;
	logic                   bad;
	logic                   is_req;
	logic                   start;
	logic                   issue;
	logic                   issue_last;
	logic                   vld_s1;
	logic                   last_s1;
	logic                   out_free;
	logic                   load_now;
	logic                   load_sum;

	logic signed [ELEMENT_BITS-1:0] wdata;
	logic [ELEMENT_BITS-1:0]        a_rd;
	logic [ELEMENT_BITS-1:0]        b_rd;
	logic signed [SUM_BITS-1:0]     mac_sum;
	logic                           mac_done;
	mac_ctl_t                       mac_ctl;

	rsp_item_t rsp_q;
	logic      rsp_valid_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// size in use, saturated at the store size
	assign size_ext = CMP_BITS'(size_q);
	assign n_act    = (size_ext > MAX_CMP) ? MAX_CMP : size_ext;

	// item decode and range check
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign bad       = (CMP_BITS'(req.row) >= n_act) || (CMP_BITS'(req.col) >= n_act);
	assign is_req    = (req.action == ACT_REQUEST);
	assign start     = accept && is_req && !bad;
	assign load_now  = accept && (req.action != ACT_NONE) && !start;
	assign in_row    = IDX_BITS'(req.row);
	assign in_col    = IDX_BITS'(req.col);
	assign wdata     = ELEMENT_BITS'(req.value);

	// sequencer
	assign issue      = (state_q == ST_WALK);
	assign issue_last = issue && (k_q == CNT_BITS'(n_q - 1'b1));
	assign load_sum   = (state_q == ST_RESULT) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			last_s1 <= issue_last;
			if (start) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= in_row;
			col_q <= in_col;
			n_q   <= CNT_BITS'(n_act);
		end
	end

	assign k_idx = k_q[IDX_BITS-1:0];

	// matrix stores
	smm_ram #(
		.WIDTH     (ELEMENT_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_first (
		.clk   (clk),
		.we    (accept && (req.action == ACT_WR_FIRST) && !bad),
		.waddr ({in_row, in_col}),
		.wdata (wdata),
		.raddr ({row_q, k_idx}),
		.rdata (a_rd)
	);

	smm_ram #(
		.WIDTH     (ELEMENT_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_second (
		.clk   (clk),
		.we    (accept && (req.action == ACT_WR_SECOND) && !bad),
		.waddr ({in_row, in_col}),
		.wdata (wdata),
		.raddr ({k_idx, col_q}),
		.rdata (b_rd)
	);

	// shared multiply-accumulate
	assign mac_ctl = '{clr: start, vld: vld_s1, last: last_s1};

	smm_mac #(
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      ($signed(a_rd)),
		.b      ($signed(b_rd)),
		.sum    (mac_sum),
		.done   (mac_done)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_now || load_sum) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sum) begin
			rsp_q.product_sum <= mac_sum;
			rsp_q.index_error <= 1'b0;
		end else if (load_now) begin
			rsp_q.product_sum <= '0;
			rsp_q.index_error <= bad;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// sequencer state stays one-hot
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");

	// the accumulator finishes only while waiting for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("accumulate finished outside drain");

	// a flagged result carries a zero sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.index_error) |-> (rsp.product_sum == '0))
		else $error("flagged result with nonzero sum");

	// a request in range starts the walk at the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_WALK) && (k_q == '0))
		else $error("request did not start the walk");

endmodule
